// ===== hw/rtl/npr_pkg.sv =====
`timescale 1ns / 1ps

package npr_pkg;

    // Default store depth for the target palette and the index mapping
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Fixed field widths
    localparam int CH_W    = 8;   // color channel
    localparam int IDX8_W  = 8;   // entry index, mapped index
    localparam int CNT_W   = 9;   // target count register
    localparam int DIST_W  = 10;  // Manhattan distance, at most 3 * 255
    localparam int CH_SHIFT = 2;  // 8-bit image channel down to 6-bit space

    // Largest distance code, above any real distance
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_MAP   = 2'd2,
        OP_REMAP = 2'd3
    } t_opcode;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;       // latch request payload
        logic tgt_wr;       // write target palette entry
        logic scan_start;   // reset search state
        logic scan_step;    // issue one target read and advance
        logic latch_map;    // capture mapping read data as result
        logic res_pass;     // result is the request index itself
        logic map_wr;       // write result into the index mapping
        logic map_wr_zero;  // mapping write goes to entry 0
        logic valid_clear;  // drop every mapping entry
        logic out_load;     // move result into the output register
    } t_ctl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic live_zero;      // no target entries searched
        logic in_idx_ok;      // request index lies inside the store
        logic reg_idx_ok;     // latched index lies inside the store
        logic scan_last;      // current read is the last target entry
        logic out_free;       // output register can take a result
    } t_dp_sts;

endpackage

// ===== hw/rtl/nearest_palette_remapper.sv =====
`timescale 1ns / 1ps

// Nearest palette remapper.
// Input channel i_in_valid / o_in_stall carries requests: opcode, entry_index
// and red, green, blue. Output channel o_out_valid / i_out_stall carries
// results: mapped_index and from_pixel. i_cfg_wr_en writes target_count.
// Load-target gives no result. Remap-pixel steps through accept, mapping RAM
// read and commit; a pass-through remap goes from accept straight to commit.
// Map-colour and clear walk the target palette RAM one entry a cycle over the
// N searched entries (registered RAM read, then compare), then commit; with
// zero count map-colour passes through to commit and clear only drops the mapping.
// Requests are handled one at a time; each RAM has a single read port.
// Reset zeroes target_count and marks every mapping entry as zero at once;
// the target palette holds nothing defined until loaded.
// A stalled result stays in the output register while the next request is
// accepted; a later result waits in the commit step until the register frees.
module nearest_palette_remapper #(
    parameter int PALETTE_ENTRIES = npr_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [npr_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [npr_pkg::IDX8_W-1:0]  i_entry_index,
    input  logic [npr_pkg::CH_W-1:0]    i_red,
    input  logic [npr_pkg::CH_W-1:0]    i_green,
    input  logic [npr_pkg::CH_W-1:0]    i_blue,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [npr_pkg::IDX8_W-1:0]  o_mapped_index,
    output logic                        o_from_pixel
);

    import npr_pkg::*;

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    // Sequence requests
    npr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Stores, search and output register
    npr_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_mapped_index (o_mapped_index),
        .o_from_pixel   (o_from_pixel),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule

// ===== hw/rtl/npr_ram.sv =====
`timescale 1ns / 1ps

module npr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/npr_ctrl.sv =====
`timescale 1ns / 1ps

module npr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  npr_pkg::t_dp_sts  i_sts,
    output npr_pkg::t_ctl_cmd o_cmd
);

    import npr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_FINISH = 5'b00100,
        S_MAPRD  = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state   r_state, n_state;
    t_opcode  r_op, n_op;
    t_ctl_cmd cmd;
    logic     accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Sequence each request
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    n_op       = t_opcode'(i_opcode);
                    case (t_opcode'(i_opcode))
                        OP_LOAD: begin
                            cmd.tgt_wr = i_sts.in_idx_ok;
                        end
                        OP_CLEAR: begin
                            cmd.valid_clear = 1'b1;
                            if (!i_sts.live_zero) begin
                                cmd.scan_start = 1'b1;
                                n_state        = S_SEARCH;
                            end
                        end
                        OP_MAP: begin
                            if (i_sts.live_zero) begin
                                cmd.res_pass = 1'b1;
                                n_state      = S_COMMIT;
                            end else begin
                                cmd.scan_start = 1'b1;
                                n_state        = S_SEARCH;
                            end
                        end
                        OP_REMAP: begin
                            if (i_sts.live_zero || !i_sts.in_idx_ok) begin
                                cmd.res_pass = 1'b1;
                                n_state      = S_COMMIT;
                            end else begin
                                n_state = S_MAPRD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Last compare lands at the end of this cycle
                n_state = S_COMMIT;
            end
            S_MAPRD: begin
                cmd.latch_map = 1'b1;
                n_state       = S_COMMIT;
            end
            S_COMMIT: begin
                if (r_op == OP_CLEAR) begin
                    cmd.map_wr      = 1'b1;
                    cmd.map_wr_zero = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.map_wr   = (r_op == OP_MAP) && !i_sts.live_zero &&
                                   i_sts.reg_idx_ok;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LOAD;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

// ===== hw/rtl/npr_datapath.sv =====
`timescale 1ns / 1ps

module npr_datapath #(
    parameter int PALETTE_ENTRIES = npr_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [npr_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic [1:0]                  i_opcode,
    input  logic [npr_pkg::IDX8_W-1:0]  i_entry_index,
    input  logic [npr_pkg::CH_W-1:0]    i_red,
    input  logic [npr_pkg::CH_W-1:0]    i_green,
    input  logic [npr_pkg::CH_W-1:0]    i_blue,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [npr_pkg::IDX8_W-1:0]  o_mapped_index,
    output logic                        o_from_pixel,
    input  npr_pkg::t_ctl_cmd           i_cmd,
    output npr_pkg::t_dp_sts            o_sts
);

    import npr_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [CNT_W-1:0] ENTRIES = CNT_W'(PALETTE_ENTRIES);

    logic [CNT_W-1:0]    r_target_count;
    logic [CNT_W-1:0]    live;
    logic [IDX8_W-1:0]   r_idx;
    logic                r_from_pix;
    logic [CH_W-1:0]     r_q_red, r_q_green, r_q_blue;
    logic                use_query;
    logic [CNT_W-1:0]    r_scan;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [DIST_W-1:0]   r_best_dist;
    logic [IDX8_W-1:0]   r_result;
    logic [PALETTE_ENTRIES-1:0] r_map_vld;
    logic                r_out_valid;
    logic [IDX8_W-1:0]   r_out_index;
    logic                r_out_from_pix;
    logic [3*CH_W-1:0]   tgt_rd;
    logic [IDX8_W-1:0]   map_rd;
    logic [IDX_W-1:0]    map_wr_addr;
    logic [CH_W-1:0]     ad_red, ad_green, ad_blue;
    logic [DIST_W-1:0]   cur_dist;

    // Saturate the searched count at the store depth
    assign live = (r_target_count > ENTRIES) ? ENTRIES : r_target_count;

    assign o_sts.live_zero  = (live == '0);
    assign o_sts.in_idx_ok  = ({1'b0, i_entry_index} < ENTRIES);
    assign o_sts.reg_idx_ok = ({1'b0, r_idx} < ENTRIES);
    assign o_sts.scan_last  = (r_scan == live - CNT_W'(1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // Black query for index 0 and for clear
    assign use_query = (i_opcode == OP_MAP) && (i_entry_index != '0);

    npr_ram #(
        .WIDTH (3 * CH_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_target_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.tgt_wr),
        .i_wr_addr (i_entry_index[IDX_W-1:0]),
        .i_wr_data ({i_red, i_green, i_blue}),
        .i_rd_addr (r_scan[IDX_W-1:0]),
        .o_rd_data (tgt_rd)
    );

    assign map_wr_addr = i_cmd.map_wr_zero ? '0 : r_idx[IDX_W-1:0];

    npr_ram #(
        .WIDTH (IDX8_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.map_wr),
        .i_wr_addr (map_wr_addr),
        .i_wr_data (r_result),
        .i_rd_addr (i_entry_index[IDX_W-1:0]),
        .o_rd_data (map_rd)
    );

    // Manhattan distance of the entry read last cycle
    always_comb begin
        ad_red   = (r_q_red > tgt_rd[3*CH_W-1:2*CH_W]) ?
                   r_q_red - tgt_rd[3*CH_W-1:2*CH_W] : tgt_rd[3*CH_W-1:2*CH_W] - r_q_red;
        ad_green = (r_q_green > tgt_rd[2*CH_W-1:CH_W]) ?
                   r_q_green - tgt_rd[2*CH_W-1:CH_W] : tgt_rd[2*CH_W-1:CH_W] - r_q_green;
        ad_blue  = (r_q_blue > tgt_rd[CH_W-1:0]) ?
                   r_q_blue - tgt_rd[CH_W-1:0] : tgt_rd[CH_W-1:0] - r_q_blue;
        cur_dist = DIST_W'(ad_red) + DIST_W'(ad_green) + DIST_W'(ad_blue);
    end

    // Capture request payload and run the search
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx      <= i_entry_index;
            r_from_pix <= (i_opcode == OP_REMAP);
            r_q_red    <= use_query ? (i_red >> CH_SHIFT) : '0;
            r_q_green  <= use_query ? (i_green >> CH_SHIFT) : '0;
            r_q_blue   <= use_query ? (i_blue >> CH_SHIFT) : '0;
        end
        r_cmp_idx <= r_scan[IDX_W-1:0];
        if (i_cmd.scan_start) begin
            r_scan      <= '0;
            r_best_dist <= DIST_MAX;
            r_result    <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            if (i_cmd.res_pass) begin
                r_result <= i_entry_index;
            end else if (i_cmd.latch_map) begin
                r_result <= r_map_vld[r_idx[IDX_W-1:0]] ? map_rd : '0;
            end else if (r_cmp_vld && (cur_dist < r_best_dist)) begin
                r_best_dist <= cur_dist;
                r_result    <= IDX8_W'(r_cmp_idx);
            end
        end
    end

    // Hold the output register until taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index    <= r_result;
            r_out_from_pix <= r_from_pix;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_count <= '0;
            r_map_vld      <= '0;
            r_cmp_vld      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target_count <= i_cfg_wr_data;
            end
            if (i_cmd.valid_clear) begin
                r_map_vld <= '0;
            end else if (i_cmd.map_wr) begin
                r_map_vld[map_wr_addr] <= 1'b1;
            end
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mapped_index = r_out_index;
    assign o_from_pixel   = r_out_from_pix;

endmodule
